// ----- hw/rtl/bpe_pkg.sv -----
// ----------------------------------------------------------------------------
// Bitwise pattern pixel effect - shared definitions
// Transaction payload types, mode codes and arithmetic constants.
// ----------------------------------------------------------------------------
package bpe_pkg;

   // Coordinate bits taken into the pattern (8 to 16)
   localparam int COORD_BITS = 12;
   localparam int COORD_W    = 12;
   localparam int CHAN_W     = 8;
   localparam int MODE_W     = 3;
   localparam int LEVEL_W    = 4;
   localparam int SHIFT_W    = 4;
   localparam int SUM_W      = 10;

   // floor(sum / 48) == (sum * RECIP48) >> RECIP_SHIFT for every sum up to 765
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP_W     = 11;
   localparam logic [RECIP_W-1:0] RECIP48 = RECIP_W'(1366);
   localparam int PROD48_W    = SUM_W + RECIP_W;

   // Level from which the pattern switches from AND to XOR
   localparam logic [LEVEL_W-1:0] LEVEL_XOR = LEVEL_W'(8);
   localparam logic [SHIFT_W-1:0] SHIFT_MAX = SHIFT_W'(8);

   localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((32'd1 << COORD_BITS) - 32'd1);

   typedef enum logic [MODE_W-1:0] {
      MODE_MONO = 3'd0,
      MODE_MUL  = 3'd1,
      MODE_XOR  = 3'd2,
      MODE_AND  = 3'd3,
      MODE_OR   = 3'd4
   } mode_type;

   typedef struct packed {
      logic [CHAN_W-1:0]  red_in;
      logic [CHAN_W-1:0]  green_in;
      logic [CHAN_W-1:0]  blue_in;
      logic [CHAN_W-1:0]  alpha_in;
      logic [COORD_W-1:0] coord_x;
      logic [COORD_W-1:0] coord_y;
   } pixel_in_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
      logic [CHAN_W-1:0] alpha_out;
   } pixel_out_type;

   // Pattern stage result handed to the colour lanes
   typedef struct packed {
      logic              valid;
      logic [CHAN_W-1:0] mono;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
   } mono_stage_type;

endpackage

// ----- hw/rtl/bpe_mono.sv -----
// ----------------------------------------------------------------------------
// Bitwise pattern pixel effect - mono pattern generator
// Two stages: brightness level, then coordinate pattern shifted to a byte.
// ----------------------------------------------------------------------------
module bpe_mono
   import bpe_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  pixel_in_type   in_pixel,
   output mono_stage_type out_stage
);

   logic [SUM_W-1:0]    sum;
   logic [PROD48_W-1:0] prod48;

   logic                valid1_ff;
   logic                valid1_in;
   logic [LEVEL_W-1:0]  level_ff;
   logic [LEVEL_W-1:0]  level_in;
   logic [COORD_W-1:0]  x_ff;
   logic [COORD_W-1:0]  y_ff;
   pixel_in_type        pix1_ff;

   logic [COORD_W-1:0]  pattern;
   logic [SHIFT_W-1:0]  shift;
   logic [LEVEL_W:0]    level_inc;
   logic [2*CHAN_W-1:0] shifted;
   mono_stage_type      stage2_ff;
   mono_stage_type      stage2_in;

   // Level: floor(sum / 3) >> 4, taken as sum / 48 by reciprocal
   always_comb begin
      sum       = SUM_W'(in_pixel.red_in) + SUM_W'(in_pixel.green_in)
                + SUM_W'(in_pixel.blue_in);
      prod48    = PROD48_W'(sum) * PROD48_W'(RECIP48);
      level_in  = prod48[RECIP_SHIFT +: LEVEL_W];
      valid1_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= valid1_in;
      end
   end

   // Hold payload of the first stage
   always_ff @(posedge clock) begin
      level_ff <= level_in;
      x_ff     <= in_pixel.coord_x & COORD_MASK;
      y_ff     <= in_pixel.coord_y & COORD_MASK;
      pix1_ff  <= in_pixel;
   end

   // Pattern: AND below the mid level, XOR at and above it; shift and keep the low byte
   always_comb begin
      pattern   = (level_ff < LEVEL_XOR) ? (x_ff & y_ff) : (x_ff ^ y_ff);
      level_inc = {1'b0, level_ff} + (LEVEL_W+1)'(1);
      shift     = SHIFT_MAX - SHIFT_W'(level_inc >> 1);
      shifted   = {{CHAN_W{1'b0}}, pattern[CHAN_W-1:0]} << shift;

      stage2_in.valid = valid1_ff;
      stage2_in.mono  = shifted[CHAN_W-1:0];
      stage2_in.red   = pix1_ff.red_in;
      stage2_in.green = pix1_ff.green_in;
      stage2_in.blue  = pix1_ff.blue_in;
      stage2_in.alpha = pix1_ff.alpha_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage2_ff.valid <= 1'b0;
      end else begin
         stage2_ff.valid <= stage2_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      stage2_ff.mono  <= stage2_in.mono;
      stage2_ff.red   <= stage2_in.red;
      stage2_ff.green <= stage2_in.green;
      stage2_ff.blue  <= stage2_in.blue;
      stage2_ff.alpha <= stage2_in.alpha;
   end

   assign out_stage = stage2_ff;

endmodule

// ----- hw/rtl/bpe_lane.sv -----
// ----------------------------------------------------------------------------
// Bitwise pattern pixel effect - colour lane
// Combines one colour channel with the mono byte under the effect mode.
// ----------------------------------------------------------------------------
module bpe_lane
   import bpe_pkg::*;
(
   input  logic              clock,
   input  logic [MODE_W-1:0] mode,
   input  logic [CHAN_W-1:0] chan,
   input  logic [CHAN_W-1:0] mono,
   output logic [CHAN_W-1:0] result
);

   logic [2*CHAN_W-1:0] prod;
   logic [2*CHAN_W:0]   prod_adj;
   logic [CHAN_W-1:0]   quot;
   logic [CHAN_W-1:0]   result_ff;
   logic [CHAN_W-1:0]   result_in;

   // floor(p / 255) == (p + (p >> 8) + 1) >> 8 for any p up to 65534
   always_comb begin
      prod     = (2*CHAN_W)'(chan) * (2*CHAN_W)'(mono);
      prod_adj = (2*CHAN_W+1)'(prod) + (2*CHAN_W+1)'(prod >> CHAN_W)
               + (2*CHAN_W+1)'(1);
      quot     = prod_adj[CHAN_W +: CHAN_W];
   end

   // Select the combination; unused codes fall back to mono
   always_comb begin
      case (mode)
         MODE_MUL: begin
            result_in = quot;
         end
         MODE_XOR: begin
            result_in = chan ^ mono;
         end
         MODE_AND: begin
            result_in = chan & mono;
         end
         MODE_OR: begin
            result_in = chan | mono;
         end
         default: begin
            result_in = mono;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

// ----- hw/rtl/bitwise_pattern_pixel_effect.sv -----
// ----------------------------------------------------------------------------
// Bitwise pattern pixel effect - top level
// Pixel in, pixel out: coordinate pattern merged into RGB, alpha kept.
// ----------------------------------------------------------------------------
//  Channel   Ports                       Handshake
//  request   start, busy, req_pixel      taken when start high, busy low
//  response  rsp_strobe, rsp_pixel       one cycle, receiver cannot stall
//  config    csr_wr_en, csr_wr_data      written when csr_wr_en high
//
//  One pixel per clock; each result passes through the registers after the level
//  multiply, the pattern shift and the per-lane multiply, in that order.
//  busy is always low: the pipeline never stalls.
//  Reset clears the pipeline valids and sets the effect mode to mono.
// ----------------------------------------------------------------------------
module bitwise_pattern_pixel_effect
   import bpe_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  pixel_in_type      req_pixel,
   output logic              rsp_strobe,
   output pixel_out_type     rsp_pixel,
   input  logic              csr_wr_en,
   input  logic [MODE_W-1:0] csr_wr_data
);

   logic [MODE_W-1:0] mode_ff;
   logic [MODE_W-1:0] mode_in;
   mono_stage_type    stage;
   logic [CHAN_W-1:0] red_res;
   logic [CHAN_W-1:0] green_res;
   logic [CHAN_W-1:0] blue_res;
   logic              valid_ff;
   logic              valid_in;
   logic [CHAN_W-1:0] alpha_ff;
   logic              accept;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // Effect mode register
   assign mode_in = csr_wr_en ? csr_wr_data : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_MONO;
      end else begin
         mode_ff <= mode_in;
      end
   end

   bpe_mono u_mono (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_pixel  (req_pixel),
      .out_stage (stage)
   );

   // Colour lanes
   bpe_lane u_lane_red (
      .clock  (clock),
      .mode   (mode_ff),
      .chan   (stage.red),
      .mono   (stage.mono),
      .result (red_res)
   );

   bpe_lane u_lane_green (
      .clock  (clock),
      .mode   (mode_ff),
      .chan   (stage.green),
      .mono   (stage.mono),
      .result (green_res)
   );

   bpe_lane u_lane_blue (
      .clock  (clock),
      .mode   (mode_ff),
      .chan   (stage.blue),
      .mono   (stage.mono),
      .result (blue_res)
   );

   // Advance the strobe and alpha alongside the lanes
   assign valid_in = stage.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      alpha_ff <= stage.alpha;
   end

   // Merge lane results into the response transaction
   always_comb begin
      rsp_strobe          = valid_ff;
      rsp_pixel.red_out   = red_res;
      rsp_pixel.green_out = green_res;
      rsp_pixel.blue_out  = blue_res;
      rsp_pixel.alpha_out = alpha_ff;
   end

endmodule
